// ===== sv/pala_pkg.sv =====
// Shared types and constants for the polyline arc length accumulator.
// No dependencies; used by pala_square and the top-level accumulator.
`default_nettype none

package pala_pkg;

  // Default sizes of the coordinate and fraction fields
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  // Fixed result field widths
  localparam int SEG_BITS   = 25;
  localparam int TOTAL_BITS = 40;
  localparam int INDEX_BITS = 16;
  localparam int OUT_BITS   = 8 * ((SEG_BITS + TOTAL_BITS + INDEX_BITS + 7) / 8);

  // Dimension register codes
  localparam int          DIM_BITS  = 2;
  localparam logic [1:0]  DIM_XY    = 2'd2;
  localparam logic [1:0]  DIM_XYZ   = 2'd3;

  // Control of a serial squarer
  typedef struct packed {
    logic load;
    logic step;
  } sq_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/pala_square.sv =====
// Bit-serial squarer: one multiplier bit per cycle while step is set, shift-add.
// Depends on pala_pkg (sq_ctrl_t).
`default_nettype none

module pala_square #(
  parameter int WIDTH = pala_pkg::COORD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire pala_pkg::sq_ctrl_t   ctrl,
  input  wire logic [WIDTH-1:0]     mag,
  output logic      [2*WIDTH-1:0]   prod
);

  logic [WIDTH-1:0]   mcand;
  logic [WIDTH-1:0]   mplier;
  logic [2*WIDTH-1:0] acc;
  logic [WIDTH:0]     upper_next;

  // Partial sum of the upper half with the current multiplier bit
  assign upper_next = {1'b0, acc[2*WIDTH-1:WIDTH]} + (mplier[0] ? {1'b0, mcand} : '0);

  // Shift-add datapath
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mcand  <= mag;
      mplier <= mag;
      acc    <= '0;
    end else if (ctrl.step) begin
      mplier <= mplier >> 1;
      acc    <= {upper_next, acc[WIDTH-1:1]};
    end
  end

  assign prod = acc;

endmodule

`default_nettype wire

// ===== sv/pala_sqrt.sv =====
// Digit-serial integer square root, one radicand bit pair per cycle.
// Appends FRAC_BITS zero pairs for a fixed-point root; no package needed.
`default_nettype none

module pala_sqrt #(
  parameter int RAD_BITS  = 34,
  parameter int FRAC_BITS = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [RAD_BITS-1:0]               radicand,
  output logic                                   done,
  output logic      [RAD_BITS/2+FRAC_BITS-1:0]   root
);

  localparam int STEPS   = RAD_BITS / 2 + FRAC_BITS;
  localparam int REM_W   = STEPS + 2;
  localparam int CNT_W   = $clog2(STEPS + 1);

  logic [RAD_BITS-1:0] rad;
  logic [REM_W-1:0]    rem;
  logic [CNT_W-1:0]    cnt;
  logic                busy;
  logic [REM_W-1:0]    rem_sh;
  logic [REM_W-1:0]    trial;
  logic                fits;

  // Bring down the next bit pair and form the trial subtrahend
  assign rem_sh = {rem[REM_W-3:0], rad[RAD_BITS-1:RAD_BITS-2]};
  assign trial  = {root, 2'b01};
  assign fits   = rem_sh >= trial;

  // Iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // Pulse once after the last iteration
      done <= !start && busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Radicand shifter, remainder and root
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= rad << 2;
      if (fits) begin
        rem  <= rem_sh - trial;
        root <= {root[STEPS-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[STEPS-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/polyline_arc_length_accumulator.sv =====
// Polyline arc length accumulator: per-point segment length, running total, index.
// Depends on pala_pkg, pala_square and pala_sqrt.
//
// Usage:
//   s_tdata carries x, y, z coordinates (signed, COORD_BITS each); s_tuser is
//   the start-of-stroke flag. m_tdata returns segment length (25 bits, FRAC_BITS
//   fraction bits, truncated), running total (40 bits, saturating) and the
//   point index within the stroke (16 bits, saturating).
//   cfg_wen/cfg_wdata write the dimension register (3 = xyz, anything else = xy).
//   The first point of a stroke (s_tuser set, or first point after reset)
//   gives zero length and index 0 and goes straight to the write state.
//   Any other point passes through the three parallel bit-serial squarers,
//   then the square root unit, then the write state. One point is in work
//   at a time: the next one is taken only once the sequencer is back in idle.
//   A finished result sits in the output register; the next point may be
//   accepted while it waits. If the receiver stalls, the following result
//   waits in the datapath until the output register frees up.
//   Reset (rst, synchronous) clears the stroke state and sets dimension to 2.
`default_nettype none

module polyline_arc_length_accumulator #(
  parameter int COORD_BITS = pala_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = pala_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // Configuration
  input  wire logic                                  cfg_wen,
  input  wire logic [pala_pkg::DIM_BITS-1:0]         cfg_wdata,
  // Point stream
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  input  wire logic [8*((3*COORD_BITS+7)/8)-1:0]     s_tdata,  // x_coord, y_coord, z_coord
  input  wire logic                                  s_tuser,  // start_stroke
  // Result stream
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  output logic [pala_pkg::OUT_BITS-1:0]              m_tdata   // segment_length,
                                                               // total_length, sample_index
);

  localparam int C      = COORD_BITS;
  localparam int SQ_W   = 2 * C;
  localparam int RAD_W  = 2 * C + 2;
  localparam int ROOT_W = C + 1 + FRAC_BITS;
  localparam int SEG_W  = pala_pkg::SEG_BITS;
  localparam int TOT_W  = pala_pkg::TOTAL_BITS;
  localparam int IDX_W  = pala_pkg::INDEX_BITS;
  localparam int CMP_W  = ROOT_W > SEG_W ? ROOT_W : SEG_W;
  localparam int SQC_W  = $clog2(C + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_WRITE
  } state_t;

  state_t state;

  logic [pala_pkg::DIM_BITS-1:0] dimension;
  logic [C-1:0]      previous_x, previous_y, previous_z;
  logic [TOT_W-1:0]  running_length;
  logic [IDX_W-1:0]  point_count;
  logic [IDX_W-1:0]  index_hold;
  logic [SEG_W-1:0]  seg_hold;
  logic [SQC_W-1:0]  sq_cnt;
  logic              root_start;

  logic [SEG_W-1:0]  out_seg;
  logic [TOT_W-1:0]  out_total;
  logic [IDX_W-1:0]  out_index;

  // Input fields
  logic [C-1:0] x_in, y_in, z_in;
  assign x_in = s_tdata[C-1:0];
  assign y_in = s_tdata[2*C-1:C];
  assign z_in = s_tdata[3*C-1:2*C];

  logic accept;
  logic first_point;
  assign s_tready    = (state == ST_IDLE);
  assign accept      = s_tvalid && s_tready;
  assign first_point = s_tuser || (point_count == '0);

  // Absolute coordinate differences
  logic signed [C:0] dx, dy, dz;
  logic        [C:0] dx_abs, dy_abs, dz_abs;
  logic [C-1:0]      dz_mag;
  assign dx = $signed({x_in[C-1], x_in}) - $signed({previous_x[C-1], previous_x});
  assign dy = $signed({y_in[C-1], y_in}) - $signed({previous_y[C-1], previous_y});
  assign dz = $signed({z_in[C-1], z_in}) - $signed({previous_z[C-1], previous_z});
  assign dx_abs = dx[C] ? $unsigned(-dx) : $unsigned(dx);
  assign dy_abs = dy[C] ? $unsigned(-dy) : $unsigned(dy);
  assign dz_abs = dz[C] ? $unsigned(-dz) : $unsigned(dz);
  assign dz_mag = (dimension == pala_pkg::DIM_XYZ) ? dz_abs[C-1:0] : '0;

  // Squarer control
  pala_pkg::sq_ctrl_t sq_ctrl;
  assign sq_ctrl.load = accept && !first_point;
  assign sq_ctrl.step = (state == ST_SQUARE);

  logic [SQ_W-1:0] sq_x, sq_y, sq_z;

  pala_square #(.WIDTH(C)) u_sq_x (
    .clk(clk), .ctrl(sq_ctrl), .mag(dx_abs[C-1:0]), .prod(sq_x)
  );
  pala_square #(.WIDTH(C)) u_sq_y (
    .clk(clk), .ctrl(sq_ctrl), .mag(dy_abs[C-1:0]), .prod(sq_y)
  );
  pala_square #(.WIDTH(C)) u_sq_z (
    .clk(clk), .ctrl(sq_ctrl), .mag(dz_mag), .prod(sq_z)
  );

  // Sum of squares feeds the root unit
  logic [RAD_W-1:0] sum_sq;
  assign sum_sq = RAD_W'(sq_x) + RAD_W'(sq_y) + RAD_W'(sq_z);

  logic              root_done;
  logic [ROOT_W-1:0] root;

  pala_sqrt #(.RAD_BITS(RAD_W), .FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk(clk), .rst(rst), .start(root_start), .radicand(sum_sq),
    .done(root_done), .root(root)
  );

  // Segment clamp and saturating total
  logic [CMP_W-1:0] root_ext;
  logic [SEG_W-1:0] seg_clamped;
  logic [TOT_W:0]   total_sum;
  logic [TOT_W-1:0] total_next;
  assign root_ext    = CMP_W'(root);
  assign seg_clamped = (root_ext > CMP_W'({SEG_W{1'b1}})) ? {SEG_W{1'b1}}
                                                          : root_ext[SEG_W-1:0];
  assign total_sum   = {1'b0, running_length} + (TOT_W + 1)'(seg_hold);
  assign total_next  = total_sum[TOT_W] ? {TOT_W{1'b1}} : total_sum[TOT_W-1:0];

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  // Sequencer, stroke state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      dimension      <= pala_pkg::DIM_XY;
      previous_x     <= '0;
      previous_y     <= '0;
      previous_z     <= '0;
      running_length <= '0;
      point_count    <= '0;
      sq_cnt         <= '0;
      root_start     <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      // Kick the root unit after the last squarer step
      root_start <= (state == ST_SQUARE) && (sq_cnt == SQC_W'(1));
      if (cfg_wen) begin
        dimension <= cfg_wdata;
      end
      // Drop valid on a taken result unless a new one is loaded now
      if (m_tvalid && m_tready && state != ST_WRITE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            previous_x <= x_in;
            previous_y <= y_in;
            previous_z <= z_in;
            if (first_point) begin
              running_length <= '0;
              point_count    <= IDX_W'(1);
              index_hold     <= '0;
              seg_hold       <= '0;
              state          <= ST_WRITE;
            end else begin
              index_hold <= point_count;
              if (point_count != {IDX_W{1'b1}}) begin
                point_count <= point_count + 1'b1;
              end
              sq_cnt <= SQC_W'(C);
              state  <= ST_SQUARE;
            end
          end
        end
        ST_SQUARE: begin
          sq_cnt <= sq_cnt - 1'b1;
          if (sq_cnt == SQC_W'(1)) begin
            state <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (root_done) begin
            seg_hold <= seg_clamped;
            state    <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (out_free) begin
            running_length <= total_next;
            out_seg        <= seg_hold;
            out_total      <= total_next;
            out_index      <= index_hold;
            m_tvalid       <= 1'b1;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = pala_pkg::OUT_BITS'({out_index, out_total, out_seg});

  // Only one point in work: no accept right after an accept
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("point accepted while another is in work");

  // The first point of a stroke reports zero length and zero total
  a_first_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_index == '0) |-> (out_seg == '0 && out_total == '0))
    else $error("nonzero length on first point");

  // The root unit finishes only while the sequencer waits for it
  a_root_state: assert property (@(posedge clk) disable iff (rst)
    root_done |-> state == ST_ROOT)
    else $error("root result outside root phase");

  // Output register is loaded only when free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(out_total))
    else $error("held result overwritten");

endmodule

`default_nettype wire
